### sv/equity_series_risk_metrics_defines.svh
// Assertion macros for the equity series risk metrics block.
`ifndef EQUITY_SERIES_RISK_METRICS_DEFINES_SVH
`define EQUITY_SERIES_RISK_METRICS_DEFINES_SVH
`ifndef SYNTH
`define ESRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ESRM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define ESRM_ASSERT(lbl, prop, msg)
`define ESRM_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### sv/esrm_pkg.sv
`default_nettype none
package esrm_pkg;

  localparam int EQ_W             = 32;
  localparam int RET_W            = 32;
  localparam int DD_W             = 25;
  localparam int CNT_OUT_W        = 21;
  localparam int BPY_W            = 20;
  localparam int RSUM_W           = 52;
  localparam int DIV_W            = 64;
  localparam int ROOT_W           = 32;
  localparam int ANN_W            = 27;
  localparam int DD_FRAC          = 24;
  localparam int TOT_FRAC         = 16;
  localparam int COUNT_BITS_DEF   = 20;
  localparam int RET_FRAC_DEF     = 24;

  localparam logic [BPY_W-1:0] BPY_RESET = 20'd252;
  localparam logic [DD_W-1:0]  DD_ONE    = 25'h1000000;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RET_DIV,
    OP_RET_SAT,
    OP_RET_SQ,
    OP_RET_ACC,
    OP_DD_DIV,
    OP_DD_UPD,
    OP_TOT_DIV,
    OP_TOT_UPD,
    OP_ANN_SQRT,
    OP_ANN_UPD,
    OP_MEAN_DIV,
    OP_MEAN_SAT,
    OP_MEAN_SQ,
    OP_EX2_DIV,
    OP_VAR_SQRT,
    OP_SHP_MUL,
    OP_SHP_DIV,
    OP_SHP_UPD,
    OP_DSQ_DIV,
    OP_DEV_SQRT,
    OP_SRT_MUL,
    OP_SRT_DIV,
    OP_SRT_UPD,
    OP_EMIT
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RET_DIV,
    S_RET_SAT,
    S_RET_SQ,
    S_RET_ACC,
    S_DD_DIV,
    S_DD_UPD,
    S_TOT_DIV,
    S_TOT_UPD,
    S_ANN_SQRT,
    S_ANN_UPD,
    S_MEAN_DIV,
    S_MEAN_SAT,
    S_MEAN_SQ,
    S_EX2_DIV,
    S_VAR_SQRT,
    S_SHP_MUL,
    S_SHP_DIV,
    S_SHP_UPD,
    S_DSQ_DIV,
    S_DEV_SQRT,
    S_SRT_MUL,
    S_SRT_DIV,
    S_SRT_UPD,
    S_EMIT,
    S_WAIT
  } state_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic last;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [RET_W-1:0] sat32(input logic neg,
                                                    input logic [DIV_W-1:0] q);
    logic signed [RET_W-1:0] res;
    if (!neg) begin
      if (q > DIV_W'(32'h7FFFFFFF)) res = 32'sh7FFFFFFF;
      else res = signed'(q[RET_W-1:0]);
    end else begin
      if (q > DIV_W'(32'h80000000)) res = 32'sh80000000;
      else res = signed'(-q[RET_W-1:0]);
    end
    return res;
  endfunction

  function automatic logic [DIV_W-1:0] sat_add64(input logic [DIV_W-1:0] a,
                                                 input logic [DIV_W-1:0] b);
    logic [DIV_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIV_W] ? '1 : s[DIV_W-1:0];
  endfunction

endpackage
`default_nettype wire

### sv/esrm_in_if.sv
`default_nettype none
interface esrm_in_if;
  import esrm_pkg::*;
  logic            valid;
  logic            ready;
  logic [EQ_W-1:0] equity;
  logic            last_bar;
  modport source (output valid, output equity, output last_bar, input ready);
  modport sink (input valid, input equity, input last_bar, output ready);
endinterface
`default_nettype wire

### sv/esrm_out_if.sv
`default_nettype none
interface esrm_out_if;
  import esrm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [RET_W-1:0]      total_return;
  logic [DD_W-1:0]       deepest_fall;
  logic [RET_W-1:0]      sharpe;
  logic [RET_W-1:0]      sortino;
  logic [CNT_OUT_W-1:0]  bar_count;
  modport source (output valid, output total_return, output deepest_fall, output sharpe,
                  output sortino, output bar_count, input ready);
  modport sink (input valid, input total_return, input deepest_fall, input sharpe,
                input sortino, input bar_count, output ready);
endinterface
`default_nettype wire

### sv/esrm_div.sv
`default_nettype none
module esrm_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [esrm_pkg::DIV_W-1:0] num_i,
  input  wire logic [esrm_pkg::DIV_W-1:0] den_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [esrm_pkg::DIV_W-1:0]      quot_o
);
  import esrm_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] rem_q, quo_q, den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DIV_W:0]   shifted;
  logic             fits;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= DIV_W'(shifted - {1'b0, den_q});
      end else begin
        rem_q <= shifted[DIV_W-1:0];
      end
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule
`default_nettype wire

### sv/esrm_sqrt.sv
`default_nettype none
module esrm_sqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [esrm_pkg::DIV_W-1:0] x_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [esrm_pkg::ROOT_W-1:0]     root_o
);
  import esrm_pkg::*;

  localparam int STEPS = DIV_W / 2;
  localparam int CW    = $clog2(STEPS);

  logic [DIV_W-1:0] x_q, res_q, bit_q;
  logic [DIV_W-1:0] trial;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      res_q <= '0;
      bit_q <= DIV_W'(1) << (DIV_W - 2);
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];
endmodule
`default_nettype wire

### sv/esrm_ctrl.sv
`default_nettype none
`include "equity_series_risk_metrics_defines.svh"
module esrm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire esrm_pkg::dp_status_t status_i,
  output esrm_pkg::dp_cmd_t         cmd_o
);
  import esrm_pkg::*;

  state_e state_q, state_d, ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_RET_DIV;
        end
      end
      S_RET_DIV: begin
        cmd_o.op = OP_RET_DIV;
        state_d  = S_WAIT;
        ret_d    = S_RET_SAT;
      end
      S_RET_SAT: begin
        cmd_o.op = OP_RET_SAT;
        state_d  = S_RET_SQ;
      end
      S_RET_SQ: begin
        cmd_o.op = OP_RET_SQ;
        state_d  = S_RET_ACC;
      end
      S_RET_ACC: begin
        cmd_o.op = OP_RET_ACC;
        state_d  = S_DD_DIV;
      end
      S_DD_DIV: begin
        cmd_o.op = OP_DD_DIV;
        state_d  = S_WAIT;
        ret_d    = S_DD_UPD;
      end
      S_DD_UPD: begin
        cmd_o.op = OP_DD_UPD;
        state_d  = status_i.last ? S_TOT_DIV : S_IDLE;
      end
      S_TOT_DIV: begin
        cmd_o.op = OP_TOT_DIV;
        state_d  = S_WAIT;
        ret_d    = S_TOT_UPD;
      end
      S_TOT_UPD: begin
        cmd_o.op = OP_TOT_UPD;
        state_d  = S_ANN_SQRT;
      end
      S_ANN_SQRT: begin
        cmd_o.op = OP_ANN_SQRT;
        state_d  = S_WAIT;
        ret_d    = S_ANN_UPD;
      end
      S_ANN_UPD: begin
        cmd_o.op = OP_ANN_UPD;
        state_d  = S_MEAN_DIV;
      end
      S_MEAN_DIV: begin
        cmd_o.op = OP_MEAN_DIV;
        state_d  = S_WAIT;
        ret_d    = S_MEAN_SAT;
      end
      S_MEAN_SAT: begin
        cmd_o.op = OP_MEAN_SAT;
        state_d  = S_MEAN_SQ;
      end
      S_MEAN_SQ: begin
        cmd_o.op = OP_MEAN_SQ;
        state_d  = S_EX2_DIV;
      end
      S_EX2_DIV: begin
        cmd_o.op = OP_EX2_DIV;
        state_d  = S_WAIT;
        ret_d    = S_VAR_SQRT;
      end
      S_VAR_SQRT: begin
        cmd_o.op = OP_VAR_SQRT;
        state_d  = S_WAIT;
        ret_d    = S_SHP_MUL;
      end
      S_SHP_MUL: begin
        cmd_o.op = OP_SHP_MUL;
        state_d  = S_SHP_DIV;
      end
      S_SHP_DIV: begin
        cmd_o.op = OP_SHP_DIV;
        state_d  = S_WAIT;
        ret_d    = S_SHP_UPD;
      end
      S_SHP_UPD: begin
        cmd_o.op = OP_SHP_UPD;
        state_d  = S_DSQ_DIV;
      end
      S_DSQ_DIV: begin
        cmd_o.op = OP_DSQ_DIV;
        state_d  = S_WAIT;
        ret_d    = S_DEV_SQRT;
      end
      S_DEV_SQRT: begin
        cmd_o.op = OP_DEV_SQRT;
        state_d  = S_WAIT;
        ret_d    = S_SRT_MUL;
      end
      S_SRT_MUL: begin
        cmd_o.op = OP_SRT_MUL;
        state_d  = S_SRT_DIV;
      end
      S_SRT_DIV: begin
        cmd_o.op = OP_SRT_DIV;
        state_d  = S_WAIT;
        ret_d    = S_SRT_UPD;
      end
      S_SRT_UPD: begin
        cmd_o.op = OP_SRT_UPD;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      S_WAIT: begin
        if (status_i.done) begin
          state_d = ret_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `ESRM_ASSERT(a_wait_unit, state_q != S_WAIT || status_i.busy || status_i.done, "wait without unit")
  `ESRM_ASSERT_NEXT(a_load_next, cmd_o.op == OP_LOAD, state_q == S_RET_DIV, "load not followed")
  `ESRM_ASSERT(a_ready_idle, !in_ready_o || state_q == S_IDLE, "ready outside idle")
endmodule
`default_nettype wire

### sv/esrm_datapath.sv
`default_nettype none
`include "equity_series_risk_metrics_defines.svh"
module esrm_datapath #(
  parameter int COUNT_BITS       = esrm_pkg::COUNT_BITS_DEF,
  parameter int RETURN_FRAC_BITS = esrm_pkg::RET_FRAC_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [esrm_pkg::BPY_W-1:0]     cfg_wdata_i,
  input  wire logic [esrm_pkg::EQ_W-1:0]      equity_i,
  input  wire logic                           last_bar_i,
  input  wire esrm_pkg::dp_cmd_t              cmd_i,
  output esrm_pkg::dp_status_t                status_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [esrm_pkg::RET_W-1:0]          total_return_o,
  output logic [esrm_pkg::DD_W-1:0]           deepest_fall_o,
  output logic [esrm_pkg::RET_W-1:0]          sharpe_o,
  output logic [esrm_pkg::RET_W-1:0]          sortino_o,
  output logic [esrm_pkg::CNT_OUT_W-1:0]      bar_count_o
);
  import esrm_pkg::*;

  localparam int CNT_W = COUNT_BITS + 1;

  logic [BPY_W-1:0]         bpy_q;
  logic [EQ_W-1:0]          first_q, prev_q, peak_q;
  logic [DD_W-1:0]          worst_q;
  logic signed [RSUM_W-1:0] rsum_q;
  logic [DIV_W-1:0]         rsq_q, dsq_q;
  logic [CNT_W-1:0]         dcnt_q, items_q;
  logic                     out_valid_q;

  logic [EQ_W-1:0]          cur_q;
  logic                     last_q, neg_q;
  logic signed [RET_W-1:0]  r_q, mean_q, total_q, sharpe_q;
  logic [DIV_W-1:0]         prod_q, m2_q;
  logic [ANN_W-1:0]         ann_q;
  logic [ROOT_W-1:0]        dev_q;
  logic [RET_W-1:0]         out_tot_q, out_shp_q, out_srt_q;
  logic [DD_W-1:0]          out_dd_q;
  logic [CNT_OUT_W-1:0]     out_cnt_q;

  logic                     div_start, div_busy, div_done, div_neg;
  logic [DIV_W-1:0]         div_num, div_den, quot;
  logic                     sqrt_start, sqrt_busy, sqrt_done;
  logic [DIV_W-1:0]         sqrt_x;
  logic [ROOT_W-1:0]        root;
  logic [ROOT_W-1:0]        mul_a, mul_b;
  logic [2*ROOT_W-1:0]      mul_p;

  logic [CNT_W-1:0]         n;
  logic                     n_zero;
  logic [EQ_W-1:0]          diff_cp, diff_pc, diff_cf;
  logic [RSUM_W-1:0]        rsum_mag;
  logic [ROOT_W-1:0]        r_mag, mean_mag;
  logic [DIV_W-1:0]         var_raw, var_cap, sq;
  logic [RSUM_W:0]          rsum_ext;
  logic signed [RSUM_W:0]   rsum_new;

  localparam logic [DIV_W-1:0] VAR_CAP = {DIV_W{1'b1}} >> RETURN_FRAC_BITS;

  assign n        = items_q - 1'b1;
  assign n_zero   = (n == '0);
  assign diff_cp  = (cur_q >= prev_q) ? cur_q - prev_q : prev_q - cur_q;
  assign diff_pc  = peak_q - cur_q;
  assign diff_cf  = (cur_q >= first_q) ? cur_q - first_q : first_q - cur_q;
  assign rsum_mag = rsum_q[RSUM_W-1] ? $unsigned(-rsum_q) : $unsigned(rsum_q);
  assign r_mag    = r_q[RET_W-1] ? $unsigned(-r_q) : $unsigned(r_q);
  assign mean_mag = mean_q[RET_W-1] ? $unsigned(-mean_q) : $unsigned(mean_q);
  assign sq       = prod_q >> RETURN_FRAC_BITS;
  assign rsum_ext = {rsum_q[RSUM_W-1], rsum_q};
  assign rsum_new = signed'(rsum_ext) + (RSUM_W+1)'(r_q);
  assign mul_p    = mul_a * mul_b;

  always_comb begin
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = DIV_W'(1);
    div_neg    = 1'b0;
    sqrt_start = 1'b0;
    sqrt_x     = '0;
    mul_a      = '0;
    mul_b      = '0;
    var_raw    = '0;
    case (cmd_i.op)
      OP_RET_DIV: begin
        div_start = 1'b1;
        div_neg   = cur_q < prev_q;
        if (items_q != '0 && prev_q != '0) begin
          div_num = {{(DIV_W-EQ_W){1'b0}}, diff_cp} << RETURN_FRAC_BITS;
          div_den = DIV_W'(prev_q);
        end
      end
      OP_DD_DIV: begin
        div_start = 1'b1;
        if (peak_q != '0) begin
          div_num = {{(DIV_W-EQ_W){1'b0}}, diff_pc} << DD_FRAC;
          div_den = DIV_W'(peak_q);
        end
      end
      OP_TOT_DIV: begin
        div_start = 1'b1;
        div_neg   = cur_q < first_q;
        if (first_q != '0) begin
          div_num = {{(DIV_W-EQ_W){1'b0}}, diff_cf} << TOT_FRAC;
          div_den = DIV_W'(first_q);
        end
      end
      OP_ANN_SQRT: begin
        sqrt_start = 1'b1;
        sqrt_x     = DIV_W'(bpy_q) << 32;
      end
      OP_MEAN_DIV: begin
        div_start = 1'b1;
        div_neg   = rsum_q[RSUM_W-1];
        if (!n_zero) begin
          div_num = DIV_W'(rsum_mag);
          div_den = DIV_W'(n);
        end
      end
      OP_MEAN_SQ: begin
        mul_a = mean_mag;
        mul_b = mean_mag;
      end
      OP_EX2_DIV: begin
        div_start = 1'b1;
        if (!n_zero) begin
          div_num = rsq_q;
          div_den = DIV_W'(n);
        end
      end
      OP_VAR_SQRT: begin
        sqrt_start = 1'b1;
        var_raw    = (quot > m2_q) ? quot - m2_q : '0;
      end
      OP_DEV_SQRT: begin
        sqrt_start = 1'b1;
        var_raw    = quot;
      end
      OP_RET_SQ: begin
        mul_a = r_mag;
        mul_b = r_mag;
      end
      OP_SHP_MUL, OP_SRT_MUL: begin
        mul_a = mean_mag;
        mul_b = ROOT_W'(ann_q);
      end
      OP_SHP_DIV, OP_SRT_DIV: begin
        div_start = 1'b1;
        div_neg   = mean_q[RET_W-1];
        if (dev_q != '0) begin
          div_num = prod_q;
          div_den = DIV_W'(dev_q);
        end
      end
      OP_DSQ_DIV: begin
        div_start = 1'b1;
        if (dcnt_q != '0 && !n_zero) begin
          div_num = dsq_q;
          div_den = DIV_W'(dcnt_q);
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
    var_cap = (var_raw > VAR_CAP) ? VAR_CAP : var_raw;
    if (cmd_i.op == OP_VAR_SQRT || cmd_i.op == OP_DEV_SQRT) begin
      sqrt_x = var_cap << RETURN_FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpy_q       <= BPY_RESET;
      first_q     <= '0;
      prev_q      <= '0;
      peak_q      <= '0;
      worst_q     <= '0;
      rsum_q      <= '0;
      rsq_q       <= '0;
      dsq_q       <= '0;
      dcnt_q      <= '0;
      items_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bpy_q <= cfg_wdata_i;
      end
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_RET_DIV: begin
          if (items_q == '0) begin
            first_q <= cur_q;
            peak_q  <= cur_q;
          end
        end
        OP_RET_ACC: begin
          if (items_q != '0) begin
            if (rsum_new[RSUM_W] != rsum_new[RSUM_W-1]) begin
              rsum_q <= rsum_new[RSUM_W] ? {1'b1, {(RSUM_W-1){1'b0}}}
                                         : {1'b0, {(RSUM_W-1){1'b1}}};
            end else begin
              rsum_q <= rsum_new[RSUM_W-1:0];
            end
            rsq_q <= sat_add64(rsq_q, sq);
            if (r_q[RET_W-1]) begin
              dsq_q <= sat_add64(dsq_q, sq);
              if (!dcnt_q[COUNT_BITS]) dcnt_q <= dcnt_q + 1'b1;
            end
          end
          if (cur_q > peak_q) peak_q <= cur_q;
        end
        OP_DD_UPD: begin
          if (quot[DD_W-1:0] > worst_q) worst_q <= quot[DD_W-1:0];
          prev_q <= cur_q;
          if (!items_q[COUNT_BITS]) items_q <= items_q + 1'b1;
        end
        OP_EMIT: begin
          first_q     <= '0;
          prev_q      <= '0;
          peak_q      <= '0;
          worst_q     <= '0;
          rsum_q      <= '0;
          rsq_q       <= '0;
          dsq_q       <= '0;
          dcnt_q      <= '0;
          items_q     <= '0;
        end
        default: begin
          first_q <= first_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) neg_q <= div_neg;
    if (mul_a != '0 || mul_b != '0 || cmd_i.op == OP_RET_SQ || cmd_i.op == OP_MEAN_SQ ||
        cmd_i.op == OP_SHP_MUL || cmd_i.op == OP_SRT_MUL) begin
      prod_q <= mul_p;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        cur_q  <= equity_i;
        last_q <= last_bar_i;
      end
      OP_RET_SAT:  r_q     <= sat32(neg_q, quot);
      OP_TOT_UPD:  total_q <= sat32(neg_q, quot);
      OP_ANN_UPD:  ann_q   <= root[ANN_W-1:0];
      OP_MEAN_SAT: mean_q  <= sat32(neg_q, quot);
      OP_EX2_DIV:  m2_q    <= sq;
      OP_SHP_MUL, OP_SRT_MUL: dev_q <= root;
      OP_SHP_UPD:  sharpe_q <= sat32(neg_q, quot);
      OP_EMIT: begin
        out_tot_q <= total_q;
        out_dd_q  <= worst_q;
        out_shp_q <= sharpe_q;
        out_srt_q <= sat32(neg_q, quot);
        out_cnt_q <= CNT_OUT_W'(items_q);
      end
      default: begin
        cur_q <= cur_q;
      end
    endcase
  end

  esrm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  esrm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (sqrt_x),
    .busy_o  (sqrt_busy),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign status_o.busy     = div_busy | sqrt_busy;
  assign status_o.done     = div_done | sqrt_done;
  assign status_o.last     = last_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign total_return_o = out_tot_q;
  assign deepest_fall_o = out_dd_q;
  assign sharpe_o       = out_shp_q;
  assign sortino_o      = out_srt_q;
  assign bar_count_o    = out_cnt_q;

  `ESRM_ASSERT(a_dd_range, worst_q <= DD_ONE, "drawdown above one")
  `ESRM_ASSERT(a_count_order, dcnt_q <= items_q, "downside count above bar count")
  `ESRM_ASSERT_NEXT(a_emit_clear, cmd_i.op == OP_EMIT, items_q == '0 && out_valid_q, "emit")
endmodule
`default_nettype wire

### sv/equity_series_risk_metrics.sv
// Equity series risk metrics: one equity value per input request, last_bar marks the end of a
// series; on that bar one result request carries total return (Q16.16), maximum drawdown
// (Q1.24), annualized Sharpe and Sortino ratios (Q16.16, saturated) and the bar count, and the
// series state clears while the bars-per-year register is kept. Items are worked one at a time
// by a shared 64-step divider and a 32-step square-root unit: an ordinary bar takes two divisions,
// a last bar six further divisions and three square roots, and a finished result waits in an
// output register while the next bar is accepted.
`default_nettype none
module equity_series_risk_metrics #(
  parameter int COUNT_BITS       = esrm_pkg::COUNT_BITS_DEF,
  parameter int RETURN_FRAC_BITS = esrm_pkg::RET_FRAC_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [esrm_pkg::BPY_W-1:0] cfg_wdata_i,
  esrm_in_if.sink                         in_i,
  esrm_out_if.source                      out_o
);
  import esrm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  esrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  esrm_datapath #(
    .COUNT_BITS       (COUNT_BITS),
    .RETURN_FRAC_BITS (RETURN_FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .equity_i       (in_i.equity),
    .last_bar_i     (in_i.last_bar),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .total_return_o (out_o.total_return),
    .deepest_fall_o (out_o.deepest_fall),
    .sharpe_o       (out_o.sharpe),
    .sortino_o      (out_o.sortino),
    .bar_count_o    (out_o.bar_count)
  );

  assign in_i.ready = in_ready;
endmodule
`default_nettype wire
